// ----- src/sltw_pkg.sv -----
// Shared types and constants for the sleep list tick waker.
`default_nettype none

package sltw_pkg;

  // List size and derived widths.
  localparam int unsigned MAX_SLEEPERS = 16;
  localparam int unsigned IDX_W        = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_SLEEPERS + 1);

  // Reset value of the idle limit register.
  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd100;

  // Input item codes.
  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Result item kinds.
  localparam logic [1:0] KIND_WOKEN  = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // One input item.
  typedef struct packed {
    logic        func;
    logic [7:0]  thread_id;
    logic [15:0] delay;
    logic        machine_idle;
    logic        future_pending;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] woken_id;
    logic       accepted;
    logic       yield_request;
    logic       timer_off;
    logic       last;
  } out_item_t;

  // One list entry as stored in the sleeper memory.
  typedef struct packed {
    logic [7:0]  thread_id;
    logic [31:0] wake_time;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/sleep_list_tick_waker_top.sv -----
// Top level of the sleep list tick waker: sleeper memory, scan sequencer and result register.
//
// Usage: items arrive on the in_ channel (valid/ready) as sltw_pkg::in_item_t and results
// leave on the out_ channel (valid/ready) as sltw_pkg::out_item_t; the last flag marks the
// final result of each input item. cfg_wr_en/cfg_wr_data write the idle limit register.
//
// A sleep request gives one acknowledge in the cycle after its transfer, and the block is ready
// for the next item in that same cycle if the receiver takes the acknowledge. A tick walks the
// list, one entry per cycle while results are taken, through a one-port-read, one-port-write
// memory with a registered read. Woken ids leave in list order, followed by one status item;
// kept entries are written back compacted toward the head of the list during the same walk.
//
// Reset clears the tick count, list length and idle counter and loads the idle limit with
// 100; the memory itself is not cleared since only entries below the list length are read.
// When the receiver stalls, the result register holds its item and the walk pauses on the
// entry that wants to leave; no input is taken until the status item has been transferred.
`default_nettype none

module sleep_list_tick_waker_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire sltw_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output sltw_pkg::out_item_t out_data,
  input  wire                 cfg_wr_en,
  input  wire [7:0]           cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_STATUS = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]                    tick_r, tick_nxt;
  logic [sltw_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [sltw_pkg::CNT_W-1:0]     keep_r, keep_nxt;
  logic [sltw_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [7:0]                     idle_r, idle_nxt;
  logic [7:0]                     limit_r;
  logic                           mach_idle_r, mach_idle_nxt;
  logic                           future_r, future_nxt;
  logic                           out_valid_r, out_valid_nxt;
  sltw_pkg::out_item_t            out_data_r, out_data_nxt;

  // Sleeper memory and its ports.
  sltw_pkg::entry_t               mem [sltw_pkg::MAX_SLEEPERS];
  sltw_pkg::entry_t               rd_data_r;
  logic                           rd_en;
  logic [sltw_pkg::IDX_W-1:0]     rd_addr;
  logic                           wr_en;
  logic [sltw_pkg::IDX_W-1:0]     wr_addr;
  sltw_pkg::entry_t               wr_data;

  logic                           can_go;
  logic                           in_xfer;
  logic [32:0]                    wake_sum;
  logic [31:0]                    wake_time;
  logic                           due;
  logic [sltw_pkg::CNT_W-1:0]     next_idx;
  logic [7:0]                     idle_inc;

  // The result register can take a new item when empty or being drained.
  assign can_go    = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && can_go;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Wake time of a new sleeper saturates at the top of the tick range.
  assign wake_sum  = {1'b0, tick_r} + {17'd0, in_data.delay};
  assign wake_time = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];

  // Entry under inspection has reached its wake time.
  assign due       = tick_r >= rd_data_r.wake_time;
  assign next_idx  = sltw_pkg::CNT_W'(idx_r) + sltw_pkg::CNT_W'(1);
  assign idle_inc  = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    count_nxt     = count_r;
    keep_nxt      = keep_r;
    idx_nxt       = idx_r;
    idle_nxt      = idle_r;
    mach_idle_nxt = mach_idle_r;
    future_nxt    = future_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = count_r[sltw_pkg::IDX_W-1:0];
    wr_data.thread_id = in_data.thread_id;
    wr_data.wake_time = wake_time;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.func == sltw_pkg::FUNC_SLEEP) begin
            // Append to the list when there is room and acknowledge.
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.kind = sltw_pkg::KIND_ACK;
            out_data_nxt.last = 1'b1;
            if (count_r < sltw_pkg::CNT_W'(sltw_pkg::MAX_SLEEPERS)) begin
              wr_en     = 1'b1;
              count_nxt = count_r + sltw_pkg::CNT_W'(1);
              out_data_nxt.accepted = 1'b1;
            end
          end else begin
            // Advance time and start the walk over the list.
            if (tick_r != 32'hFFFF_FFFF) begin
              tick_nxt = tick_r + 32'd1;
            end
            mach_idle_nxt = in_data.machine_idle;
            future_nxt    = in_data.future_pending;
            keep_nxt      = '0;
            idx_nxt       = '0;
            if (count_r == '0) begin
              state_nxt = ST_STATUS;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // A due entry waits for room in the result register; a kept one never waits.
        if (!due || can_go) begin
          if (due) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.kind     = sltw_pkg::KIND_WOKEN;
            out_data_nxt.woken_id = rd_data_r.thread_id;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = keep_r[sltw_pkg::IDX_W-1:0];
            wr_data  = rd_data_r;
            keep_nxt = keep_r + sltw_pkg::CNT_W'(1);
          end
          idx_nxt = next_idx[sltw_pkg::IDX_W-1:0];
          if (next_idx < count_r) begin
            rd_en   = 1'b1;
            rd_addr = next_idx[sltw_pkg::IDX_W-1:0];
          end else begin
            state_nxt = ST_STATUS;
          end
        end
      end

      ST_STATUS: begin
        // Close the tick with the status item and the new list length.
        if (can_go) begin
          count_nxt     = keep_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind = sltw_pkg::KIND_STATUS;
          out_data_nxt.last = 1'b1;
          if (mach_idle_r && (keep_r == '0)) begin
            idle_nxt = idle_inc;
            out_data_nxt.timer_off = !future_r && (idle_inc > limit_r);
          end else begin
            idle_nxt = '0;
            out_data_nxt.yield_request = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sleeper memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      count_r     <= '0;
      idle_r      <= '0;
      limit_r     <= sltw_pkg::IDLE_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      count_r     <= count_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Walk registers and the result payload.
  always_ff @(posedge clk) begin
    keep_r      <= keep_nxt;
    idx_r       <= idx_nxt;
    mach_idle_r <= mach_idle_nxt;
    future_r    <= future_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire
